/* src/ax25_header_text_decoder_macros.svh */
// Assertion macros shared by the AX.25 header text decoder.
`ifndef AX25_HEADER_TEXT_DECODER_MACROS_SVH
`define AX25_HEADER_TEXT_DECODER_MACROS_SVH
`ifndef SYNTH
`define AX25_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define AX25_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AX25_ASSERT_SAME(label, ante, cons, msg)
`define AX25_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* src/ax25_pkg.sv */
// Shared types, codes and constants of the AX.25 header text decoder.
package ax25_pkg;

  localparam int MAX_DIGI_DEFAULT    = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int DEST_DEPTH          = 9;

  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_DCHAR = 3'd1;
  localparam logic [2:0] OP_DSSID = 3'd2;
  localparam logic [2:0] OP_TCHAR = 3'd3;
  localparam logic [2:0] OP_ADDR  = 3'd4;

  localparam logic [2:0] FS_GOOD     = 3'd0;
  localparam logic [2:0] FS_LONG     = 3'd1;
  localparam logic [2:0] FS_BAD_CTRL = 3'd2;
  localparam logic [2:0] FS_BAD_PID  = 3'd3;
  localparam logic [2:0] FS_SHORT    = 3'd4;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [6:0] CH_SPACE = 7'h20;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [3:0] ssid;
    logic       is_src;
    logic       hbit;
    logic       comma;
    logic       has_status;
    logic [2:0] status;
  } cmd_t;

endpackage

/* src/ax25_front.sv */
// Front end: accepts frame bytes, tracks the header fields and issues commands.
module ax25_front #(
  parameter int MAX_DIGIPEATERS = ax25_pkg::MAX_DIGI_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  input  logic [7:0]       in_frame_byte,
  input  logic             in_last_byte,
  input  logic             q_full,
  output logic             push,
  output ax25_pkg::cmd_t   cmd
);
  import ax25_pkg::*;

  localparam logic [2:0] PH_DEST = 3'd0;
  localparam logic [2:0] PH_SRC  = 3'd1;
  localparam logic [2:0] PH_DIGI = 3'd2;
  localparam logic [2:0] PH_CTRL = 3'd3;
  localparam logic [2:0] PH_PID  = 3'd4;
  localparam logic [2:0] PH_INFO = 3'd5;
  localparam logic [2:0] PH_FAIL = 3'd6;

  localparam logic [3:0] MaxDigi = 4'(MAX_DIGIPEATERS);

  logic [15:0] max_len_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  bia_r, bia_nxt;
  logic [15:0] count_r, count_nxt;
  logic [3:0]  digi_r, digi_nxt;
  logic        stopped_r, stopped_nxt;
  logic [2:0]  verdict_r, verdict_nxt;

  logic        accept;
  logic [15:0] count_inc;
  logic [3:0]  digi_step;
  logic [6:0]  ch7;
  cmd_t        c;

  assign accept    = in_valid && !q_full;
  assign ch7       = in_frame_byte[7:1];
  assign count_inc = (count_r != 16'hFFFF) ? count_r + 16'd1 : count_r;
  assign digi_step = (phase_r == PH_DIGI && digi_r != 4'd15) ? digi_r + 4'd1 : digi_r;

  always_comb begin
    phase_nxt   = phase_r;
    bia_nxt     = bia_r;
    count_nxt   = count_r;
    digi_nxt    = digi_r;
    stopped_nxt = stopped_r;
    verdict_nxt = verdict_r;
    c           = '0;
    c.op        = OP_NONE;
    c.ssid      = in_frame_byte[4:1];
    c.hbit      = in_frame_byte[7];
    c.is_src    = (phase_r == PH_SRC);
    if (accept) begin
      count_nxt = count_inc;
      unique case (phase_r) inside
        PH_DEST, PH_SRC, PH_DIGI: begin
          if (bia_r < 3'd6) begin
            bia_nxt = bia_r + 3'd1;
            c.ch    = {1'b0, ch7};
            if (ch7 != CH_SPACE) begin
              c.op = (phase_r == PH_DEST) ? OP_DCHAR : OP_TCHAR;
            end
          end else begin
            bia_nxt = 3'd0;
            if (phase_r == PH_DEST) begin
              c.op      = OP_DSSID;
              phase_nxt = PH_SRC;
            end else begin
              c.op     = OP_ADDR;
              digi_nxt = digi_step;
              c.comma  = !in_frame_byte[0] && (digi_step < MaxDigi);
              phase_nxt = c.comma ? PH_DIGI : PH_CTRL;
            end
          end
        end
        PH_CTRL: begin
          if ((in_frame_byte & 8'hEF) != 8'h03) begin
            verdict_nxt = FS_BAD_CTRL;
            phase_nxt   = PH_FAIL;
          end else begin
            phase_nxt = PH_PID;
          end
        end
        PH_PID: begin
          if (in_frame_byte != 8'hF0) begin
            verdict_nxt = FS_BAD_PID;
            phase_nxt   = PH_FAIL;
          end else begin
            phase_nxt = PH_INFO;
          end
        end
        PH_INFO: begin
          if (!stopped_r) begin
            if (in_frame_byte == 8'h00 || in_frame_byte == 8'hC0) begin
              stopped_nxt = 1'b1;
            end else begin
              c.op = OP_TCHAR;
              c.ch = in_frame_byte;
            end
          end
        end
        default: begin
        end
      endcase
      if (in_last_byte) begin
        c.has_status = 1'b1;
        if (count_inc > max_len_r) begin
          c.status = FS_LONG;
        end else if (verdict_nxt != FS_GOOD) begin
          c.status = verdict_nxt;
        end else if (phase_nxt < PH_INFO) begin
          c.status = FS_SHORT;
        end else begin
          c.status = FS_GOOD;
        end
        phase_nxt   = PH_DEST;
        bia_nxt     = 3'd0;
        count_nxt   = 16'd0;
        digi_nxt    = 4'd0;
        stopped_nxt = 1'b0;
        verdict_nxt = FS_GOOD;
      end
    end
  end

  assign push = accept && (c.op != OP_NONE || c.has_status);
  assign cmd  = c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      phase_r   <= PH_DEST;
      bia_r     <= 3'd0;
      count_r   <= 16'd0;
      digi_r    <= 4'd0;
      stopped_r <= 1'b0;
      verdict_r <= FS_GOOD;
    end else begin
      if (cfg_valid) begin
        max_len_r <= cfg_data;
      end
      phase_r   <= phase_nxt;
      bia_r     <= bia_nxt;
      count_r   <= count_nxt;
      digi_r    <= digi_nxt;
      stopped_r <= stopped_nxt;
      verdict_r <= verdict_nxt;
    end
  end

endmodule

/* src/ax25_cmd_fifo.sv */
// Short command queue between the front end and the text generator.
module ax25_cmd_fifo #(
  parameter int DEPTH = ax25_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ax25_pkg::cmd_t push_cmd,
  input  logic           pop,
  output ax25_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import ax25_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == FullCnt);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == LastPtr) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == LastPtr) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* src/ax25_back.sv */
// Back end: expands queued commands into text and status beats.
module ax25_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ax25_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_text_char,
  output logic           out_is_status,
  output logic [2:0]     out_frame_status,
  output logic           out_last_result
);
  import ax25_pkg::*;

  localparam logic [3:0] BS_IDLE   = 4'd0;
  localparam logic [3:0] BS_STORE  = 4'd1;
  localparam logic [3:0] BS_DASH   = 4'd2;
  localparam logic [3:0] BS_TEN    = 4'd3;
  localparam logic [3:0] BS_UNIT   = 4'd4;
  localparam logic [3:0] BS_GT     = 4'd5;
  localparam logic [3:0] BS_DEST   = 4'd6;
  localparam logic [3:0] BS_STAR   = 4'd7;
  localparam logic [3:0] BS_SEP    = 4'd8;
  localparam logic [3:0] BS_CHAR   = 4'd9;
  localparam logic [3:0] BS_STATUS = 4'd10;

  localparam logic [3:0] DestDepth = 4'(DEST_DEPTH);

  logic [3:0] state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [7:0] dest_r [DEST_DEPTH];
  logic [3:0] dlen_r, dlen_nxt;
  logic [3:0] idx_r, idx_nxt;

  logic       ov_r, ov_nxt;
  logic [7:0] oc_r, oc_nxt;
  logic       os_r, os_nxt;
  logic [2:0] ofs_r, ofs_nxt;
  logic       ol_r, ol_nxt;

  logic       emit_ok, want_emit, want_store, advance, store_en;
  logic [7:0] ch, dest_ch;
  logic       last, stat;
  logic [3:0] tail, after_ssid, unit;

  assign emit_ok    = !ov_r || !out_stall;
  assign tail       = cmd_r.has_status ? BS_STATUS : BS_IDLE;
  assign after_ssid = (cmd_r.op == OP_DSSID) ? tail : (cmd_r.is_src ? BS_GT : BS_STAR);
  assign unit       = (cmd_r.ssid > 4'd9) ? cmd_r.ssid - 4'd10 : cmd_r.ssid;
  assign dest_ch    = dest_r[idx_r];
  assign q_pop      = (state_r == BS_IDLE) && !q_empty;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    dlen_nxt   = dlen_r;
    want_emit  = 1'b0;
    want_store = 1'b0;
    ch         = 8'h00;
    last       = 1'b0;
    stat       = 1'b0;
    unique case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          cmd_nxt = q_head;
          unique case (q_head.op) inside
            OP_DCHAR:          state_nxt = BS_STORE;
            OP_DSSID, OP_ADDR: state_nxt = BS_DASH;
            OP_TCHAR:          state_nxt = BS_CHAR;
            default:           state_nxt = BS_STATUS;
          endcase
        end
      end
      BS_STORE: begin
        want_store = 1'b1;
        ch         = cmd_r.ch;
        state_nxt  = tail;
      end
      BS_DASH: begin
        if (cmd_r.ssid == 4'd0) begin
          state_nxt = after_ssid;
        end else begin
          want_store = (cmd_r.op == OP_DSSID);
          want_emit  = !want_store;
          ch         = CH_DASH;
          state_nxt  = BS_TEN;
        end
      end
      BS_TEN: begin
        if (cmd_r.ssid > 4'd9) begin
          want_store = (cmd_r.op == OP_DSSID);
          want_emit  = !want_store;
          ch         = CH_ONE;
        end
        state_nxt = BS_UNIT;
      end
      BS_UNIT: begin
        want_store = (cmd_r.op == OP_DSSID);
        want_emit  = !want_store;
        ch         = CH_ZERO + {4'b0000, unit};
        state_nxt  = after_ssid;
      end
      BS_GT: begin
        want_emit = 1'b1;
        ch        = CH_GT;
        idx_nxt   = 4'd0;
        state_nxt = BS_DEST;
      end
      BS_DEST: begin
        if (idx_r < dlen_r) begin
          want_emit = 1'b1;
          ch        = dest_ch;
          idx_nxt   = idx_r + 4'd1;
        end else begin
          state_nxt = BS_SEP;
        end
      end
      BS_STAR: begin
        if (cmd_r.hbit) begin
          want_emit = 1'b1;
          ch        = CH_STAR;
        end
        state_nxt = BS_SEP;
      end
      BS_SEP: begin
        want_emit = 1'b1;
        ch        = cmd_r.comma ? CH_COMMA : CH_COLON;
        last      = !cmd_r.has_status;
        state_nxt = tail;
      end
      BS_CHAR: begin
        want_emit = 1'b1;
        ch        = cmd_r.ch;
        last      = !cmd_r.has_status;
        state_nxt = tail;
      end
      BS_STATUS: begin
        want_emit = 1'b1;
        stat      = 1'b1;
        last      = 1'b1;
        dlen_nxt  = 4'd0;
        state_nxt = BS_IDLE;
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase

    advance  = !want_emit || emit_ok;
    store_en = want_store && (dlen_r < DestDepth);
    if (store_en) begin
      dlen_nxt = dlen_r + 4'd1;
    end
    if (!advance) begin
      state_nxt = state_r;
      idx_nxt   = idx_r;
      dlen_nxt  = dlen_r;
    end

    ov_nxt  = ov_r && out_stall;
    oc_nxt  = oc_r;
    os_nxt  = os_r;
    ofs_nxt = ofs_r;
    ol_nxt  = ol_r;
    if (want_emit && emit_ok) begin
      ov_nxt  = 1'b1;
      oc_nxt  = ch;
      os_nxt  = stat;
      ofs_nxt = stat ? cmd_r.status : FS_GOOD;
      ol_nxt  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      dest_r[dlen_r] <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      dlen_r  <= 4'd0;
      idx_r   <= 4'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dlen_r  <= dlen_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    oc_r  <= oc_nxt;
    os_r  <= os_nxt;
    ofs_r <= ofs_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid        = ov_r;
  assign out_text_char    = oc_r;
  assign out_is_status    = os_r;
  assign out_frame_status = ofs_r;
  assign out_last_result  = ol_r;

endmodule

/* src/ax25_header_text_decoder.sv */
// Top level of the AX.25 header text decoder.
//
// Frame bytes arrive on the in_ channel, one byte per beat, with in_last_byte
// marking the final byte of a frame. The out_ channel carries the decoded text
// SOURCE>DEST,DIGI*,...:INFO one character per beat, and after the last byte
// of each frame a status beat (out_is_status high) with the frame verdict.
// out_last_result marks the final beat caused by one input byte.
// The cfg_ channel writes max_frame_length; cfg_ready is always high, and the
// register should only be written while the block is idle.
// The front end takes one byte per cycle while in_stall is low into a command queue
// of QUEUE_DEPTH entries (four by default); the text generator pops one command
// at a time, only from its idle state, and expands it into output beats; the
// source SSID byte also prints the buffered destination.
// With an empty queue a byte's command is written into the queue, popped into the
// generator's command register, and its first beat then goes to the output register.
// When the receiver stalls, the output register holds its beat, the queue
// fills and in_stall rises. Synchronous reset clears the frame state, sets
// max_frame_length to 1024 and empties the queue and the output register.
`include "ax25_header_text_decoder_macros.svh"

module ax25_header_text_decoder #(
  parameter int MAX_DIGIPEATERS = ax25_pkg::MAX_DIGI_DEFAULT,
  parameter int QUEUE_DEPTH     = ax25_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_text_char,
  output logic        out_is_status,
  output logic [2:0]  out_frame_status,
  output logic        out_last_result
);
  import ax25_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_in, q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  ax25_front #(
    .MAX_DIGIPEATERS(MAX_DIGIPEATERS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_frame_byte(in_frame_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .push         (q_push),
    .cmd          (q_in)
  );

  ax25_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_in),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  ax25_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_text_char   (out_text_char),
    .out_is_status   (out_is_status),
    .out_frame_status(out_frame_status),
    .out_last_result (out_last_result)
  );

  `AX25_ASSERT_SAME(a_no_overflow, q_push, !q_full, "command pushed into a full queue")
  `AX25_ASSERT_SAME(a_status_last, out_valid && out_is_status,
    out_last_result && out_frame_status <= FS_SHORT, "bad status beat")
  `AX25_ASSERT_SAME(a_text_clean, out_valid && !out_is_status,
    out_frame_status == FS_GOOD, "text beat carries a status")
  `AX25_ASSERT_NEXT(a_hold_beat, out_valid && out_stall,
    out_valid && $stable(out_text_char) && $stable(out_last_result), "stalled beat changed")

endmodule

/* test/ax25_header_text_decoder_tb.sv */
// Self-checking testbench that feeds AX.25 frames to the header text decoder and checks its text.
module ax25_header_text_decoder_tb;
  import ax25_pkg::*;

  localparam int MAX_DIGI = MAX_DIGI_DEFAULT;

  localparam logic [7:0] CTRL_UI       = 8'h03;
  localparam logic [7:0] CTRL_PF_MASK  = 8'hEF;
  localparam logic [7:0] PID_NONE      = 8'hF0;
  localparam logic [7:0] INFO_END_NUL  = 8'h00;
  localparam logic [7:0] INFO_END_FEND = 8'hC0;
  localparam logic [7:0] CH_LETTER_A   = 8'h41;

  typedef enum logic [2:0] {
    FP_DEST, FP_SRC, FP_DIGI, FP_CTRL, FP_PID, FP_INFO, FP_FAIL
  } field_phase_e;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_status;
    logic [2:0] frame_status;
    logic       last_result;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_frame_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_text_char;
  logic        out_is_status;
  logic [2:0]  out_frame_status;
  logic        out_last_result;

  ax25_header_text_decoder #(
    .MAX_DIGIPEATERS(MAX_DIGI)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_frame_byte   (in_frame_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_text_char   (out_text_char),
    .out_is_status   (out_is_status),
    .out_frame_status(out_frame_status),
    .out_last_result (out_last_result)
  );

  frame_beat_t pending_bytes[$];
  logic [7:0]  frame_buf[$];
  text_beat_t  expected_text[$];
  frame_beat_t next_byte;
  text_beat_t  oldest_text;
  int          mismatch_count = 0;
  int          bytes_taken = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        quiet;

  // Decoder state of the predictor.
  logic [15:0]  max_len_model = MAX_LEN_RESET;
  field_phase_e phase;
  logic [2:0]   addr_pos;
  logic [15:0]  frame_len;
  logic [7:0]   dest_buf[DEST_DEPTH];
  logic [3:0]   dest_len;
  logic [3:0]   digi_cnt;
  logic         info_stopped;
  logic [2:0]   verdict;

  assign quiet = (bytes_taken >= 110) && (bytes_taken < 160);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic text_beat_t text_beat(input logic [7:0] c);
    text_beat = '{c, 1'b0, FS_GOOD, 1'b0};
  endfunction

  task automatic clear_frame_state();
    phase        = FP_DEST;
    addr_pos     = 3'd0;
    frame_len    = 16'd0;
    dest_len     = 4'd0;
    digi_cnt     = 4'd0;
    info_stopped = 1'b0;
    verdict      = FS_GOOD;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [6:0] ch;
    logic [3:0] ssid;
    logic       more;
    logic [2:0] status;
    logic [7:0] suffix[$];
    text_beat_t burst[$];
    if (frame_len != 16'hFFFF) frame_len++;
    case (phase)
      FP_DEST, FP_SRC, FP_DIGI: begin
        if (addr_pos < 3'd6) begin
          ch = b[7:1];
          addr_pos++;
          if (ch != CH_SPACE) begin
            if (phase == FP_DEST) begin
              if (dest_len < DEST_DEPTH) begin
                dest_buf[dest_len] = {1'b0, ch};
                dest_len++;
              end
            end else begin
              burst.push_back(text_beat({1'b0, ch}));
            end
          end
        end else begin
          more = !b[0];
          addr_pos = 3'd0;
          ssid = b[4:1];
          if (ssid != 4'd0) begin
            suffix.push_back(CH_DASH);
            if (ssid > 4'd9) suffix.push_back(CH_ONE);
            suffix.push_back(8'(CH_ZERO + 8'(ssid % 4'd10)));
          end
          if (phase == FP_DEST) begin
            foreach (suffix[i]) begin
              if (dest_len < DEST_DEPTH) begin
                dest_buf[dest_len] = suffix[i];
                dest_len++;
              end
            end
            phase = FP_SRC;
          end else begin
            foreach (suffix[i]) burst.push_back(text_beat(suffix[i]));
            if (phase == FP_SRC) begin
              burst.push_back(text_beat(CH_GT));
              for (int i = 0; i < dest_len; i++) burst.push_back(text_beat(dest_buf[i]));
            end else begin
              if (b[7]) burst.push_back(text_beat(CH_STAR));
              if (digi_cnt < 4'd15) digi_cnt++;
            end
            if (more && digi_cnt < MAX_DIGI) begin
              burst.push_back(text_beat(CH_COMMA));
              phase = FP_DIGI;
            end else begin
              burst.push_back(text_beat(CH_COLON));
              phase = FP_CTRL;
            end
          end
        end
      end
      FP_CTRL: begin
        if ((b & CTRL_PF_MASK) != CTRL_UI) begin
          verdict = FS_BAD_CTRL;
          phase = FP_FAIL;
        end else begin
          phase = FP_PID;
        end
      end
      FP_PID: begin
        if (b != PID_NONE) begin
          verdict = FS_BAD_PID;
          phase = FP_FAIL;
        end else begin
          phase = FP_INFO;
        end
      end
      FP_INFO: begin
        if (!info_stopped) begin
          if (b == INFO_END_NUL || b == INFO_END_FEND) info_stopped = 1'b1;
          else burst.push_back(text_beat(b));
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      if (frame_len > max_len_model) status = FS_LONG;
      else if (verdict != FS_GOOD) status = verdict;
      else if (phase < FP_INFO) status = FS_SHORT;
      else status = FS_GOOD;
      burst.push_back('{8'd0, 1'b1, status, 1'b0});
      clear_frame_state();
    end
    if (burst.size() != 0) burst[burst.size() - 1].last_result = 1'b1;
    foreach (burst[i]) expected_text.push_back(burst[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_frame_state();
      max_len_model = MAX_LEN_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_frame_byte, in_last_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
          next_byte = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_frame_byte <= next_byte.frame_byte;
          in_last_byte <= next_byte.last_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected beat", out_text_char, 0);
        end else begin
          oldest_text = expected_text.pop_front();
          if (out_text_char !== oldest_text.text_char)
            report_mismatch("text_char", out_text_char, oldest_text.text_char);
          if (out_is_status !== oldest_text.is_status)
            report_mismatch("is_status", out_is_status, oldest_text.is_status);
          if (out_frame_status !== oldest_text.frame_status)
            report_mismatch("frame_status", out_frame_status, oldest_text.frame_status);
          if (out_last_result !== oldest_text.last_result)
            report_mismatch("last_result", out_last_result, oldest_text.last_result);
        end
      end
      out_stall <= (hold_left != 0) || (!quiet && $urandom_range(99) < 8);
    end
  end

  // The receiver holds off once for a long stretch while a large batch is waiting.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && pending_bytes.size() >= 20) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic queue_frame();
    foreach (frame_buf[i]) pending_bytes.push_back('{frame_buf[i], i == frame_buf.size() - 1});
    frame_buf.delete();
  endtask

  task automatic add_fixed_address(input string s, input logic [3:0] ssid,
                                   input logic hbit, input logic ext);
    logic [7:0] sc;
    for (int i = 0; i < 6; i++) begin
      sc = s[i];
      frame_buf.push_back({sc[6:0], 1'b0});
    end
    frame_buf.push_back({hbit, 2'b11, ssid, ext});
  endtask

  task automatic add_address(input logic ext, input logic hbit);
    int         r;
    logic [6:0] c;
    logic [3:0] ssid;
    for (int i = 0; i < 6; i++) begin
      r = $urandom_range(9);
      if (r < 5) c = 7'(CH_LETTER_A + 8'($urandom_range(25)));
      else if (r < 7) c = 7'(CH_ZERO + 8'($urandom_range(9)));
      else if (r == 7) c = CH_SPACE;
      else if (r == 8) c = 7'd0;
      else c = 7'($urandom_range(127));
      frame_buf.push_back({c, 1'($urandom_range(1))});
    end
    r = $urandom_range(3);
    if (r == 0) ssid = 4'd0;
    else if (r == 1) ssid = 4'($urandom_range(1, 9));
    else ssid = 4'($urandom_range(15));
    frame_buf.push_back({hbit, 2'($urandom_range(3)), ssid, ext});
  endtask

  task automatic queue_random_frame(input int n_digi, input logic ext_on_last);
    int r;
    int info_len;
    int cut;
    add_address(1'($urandom_range(1)), 1'($urandom_range(1)));
    add_address(n_digi == 0 && ext_on_last, 1'($urandom_range(1)));
    for (int i = 0; i < n_digi; i++)
      add_address(i == n_digi - 1 && ext_on_last, 1'($urandom_range(1)));
    r = $urandom_range(9);
    if (r < 4) frame_buf.push_back(CTRL_UI);
    else if (r < 8) frame_buf.push_back(CTRL_UI | ~CTRL_PF_MASK);
    else frame_buf.push_back(8'($urandom_range(255)));
    r = $urandom_range(9);
    frame_buf.push_back(r < 8 ? PID_NONE : 8'($urandom_range(255)));
    info_len = $urandom_range(8);
    for (int i = 0; i < info_len; i++) begin
      r = $urandom_range(15);
      if (r == 0) frame_buf.push_back(INFO_END_NUL);
      else if (r == 1) frame_buf.push_back(INFO_END_FEND);
      else frame_buf.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(5) == 0) begin
      cut = $urandom_range(1, frame_buf.size());
      while (frame_buf.size() > cut) void'(frame_buf.pop_back());
    end
    queue_frame();
  endtask

  task automatic queue_noise();
    int len;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(255)));
    queue_frame();
  endtask

  task automatic queue_random_traffic(input int n_bytes);
    int queued;
    int before_len;
    int r;
    queued = 0;
    while (queued < n_bytes) begin
      before_len = pending_bytes.size();
      r = $urandom_range(19);
      if (r < 2) queue_noise();
      else if (r == 2) queue_random_frame(MAX_DIGI, 1'b0);
      else queue_random_frame($urandom_range(3), 1'b1);
      queued += pending_bytes.size() - before_len;
    end
  endtask

  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_text.size() != 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len_model = value;
  endtask

  initial begin
    wait (rst_n === 1'b1);
    @(negedge clk);

    frame_buf.push_back(8'hFF);
    queue_frame();
    frame_buf.push_back(8'h00);
    queue_frame();
    add_fixed_address("APZ   ", 4'd15, 1'b0, 1'b0);
    add_fixed_address("N0CALL", 4'd9, 1'b0, 1'b0);
    // A source character byte of 0x01 decodes to a zero character.
    frame_buf[frame_buf.size() - 2] = 8'h01;
    add_fixed_address("WIDE1 ", 4'd1, 1'b1, 1'b1);
    frame_buf.push_back(CTRL_UI | ~CTRL_PF_MASK);
    frame_buf.push_back(PID_NONE);
    frame_buf.push_back("H");
    frame_buf.push_back("i");
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(INFO_END_FEND);
    frame_buf.push_back("x");
    queue_frame();
    wait_until_idle();

    write_max_length(16'd0);
    @(negedge clk);
    queue_random_traffic(10);
    wait_until_idle();

    write_max_length(16'hFFFF);
    @(negedge clk);
    queue_random_frame(MAX_DIGI, 1'b0);
    wait_until_idle();

    write_max_length(16'($urandom_range(12, 40)));
    @(negedge clk);
    queue_random_traffic(15);
    wait_until_idle();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ax25_pkg.sv
src/ax25_front.sv
src/ax25_cmd_fifo.sv
src/ax25_back.sv
src/ax25_header_text_decoder.sv
test/ax25_header_text_decoder_tb.sv
